// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the mixer RTL.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: always");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/ddpm_pkg.sv -----
// Types, constants and arithmetic helpers for the differential drive PWM mixer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ddpm_pkg;

   // Field widths
   localparam int CMD_BITS      = 3;
   localparam int REQ_BITS      = 16;
   localparam int PIN_BITS      = 3;
   localparam int DUTY_BITS     = 8;
   localparam int SPEED_BITS    = DUTY_BITS + 1;
   localparam int SUM_BITS      = SPEED_BITS + 1;
   localparam int TRIM_BITS     = 8;
   localparam int LIMIT_BITS    = 16;
   localparam int TIMER_BITS    = 16;
   localparam int CMP_BITS      = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
   localparam int NUM_PINS      = 4;
   localparam int PIN_IDX_BITS  = 2;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // Duty limit
   localparam int DUTY_MAX      = 255;

   // Divide by 100 as multiply by 5243 and shift by 19; exact for products below 43690,
   // and any larger product already gives a quotient above 255, which saturates
   localparam int RECIP_MUL     = 5243;
   localparam int RECIP_SHIFT   = 19;
   localparam int COEF_BITS     = 21;
   localparam int PROD_BITS     = DUTY_BITS + COEF_BITS;
   localparam int QUOT_BITS     = PROD_BITS - RECIP_SHIFT;

   // Register reset values
   localparam logic [TRIM_BITS-1:0]  TRIM_RESET     = 8'd100;
   localparam logic [TRIM_BITS-1:0]  FLOOR_RESET    = 8'd50;
   localparam logic [TRIM_BITS-1:0]  CEILING_RESET  = 8'd150;
   localparam logic [LIMIT_BITS-1:0] WATCHDOG_RESET = 16'd1000;
   localparam logic [LIMIT_BITS-1:0] PIN_TEST_RESET = 16'd2000;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_DRIVE    = 3'd0,
      CMD_STOP     = 3'd1,
      CMD_REAPPLY  = 3'd2,
      CMD_PIN_TEST = 3'd3,
      CMD_TICK     = 3'd4
   } cmd_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_TRIM_LEFT      = 3'd0,
      CSR_TRIM_RIGHT     = 3'd1,
      CSR_REVERSE_LEFT   = 3'd2,
      CSR_REVERSE_RIGHT  = 3'd3,
      CSR_TRIM_FLOOR     = 3'd4,
      CSR_TRIM_CEILING   = 3'd5,
      CSR_WATCHDOG_LIMIT = 3'd6,
      CSR_PIN_TEST_LIMIT = 3'd7
   } csr_addr_type;

   typedef logic [DUTY_BITS-1:0] duty_type;
   typedef logic signed [SPEED_BITS-1:0] speed_type;

   // Clamp a 16-bit signed request to +-255
   function automatic speed_type clamp_req(input logic signed [REQ_BITS-1:0] v);
      speed_type r;
      if (v > REQ_BITS'(DUTY_MAX))
         r = SPEED_BITS'(DUTY_MAX);
      else if (v < -REQ_BITS'(DUTY_MAX))
         r = -SPEED_BITS'(DUTY_MAX);
      else
         r = v[SPEED_BITS-1:0];
      return r;
   endfunction

   // Magnitude of a clamped speed
   function automatic duty_type speed_mag(input speed_type s);
      speed_type n;
      n = -s;
      return s[SPEED_BITS-1] ? n[DUTY_BITS-1:0] : s[DUTY_BITS-1:0];
   endfunction

   // Mix two clamped requests with add or subtract, clamped to +-255
   function automatic speed_type mix_side(input speed_type a, input speed_type b,
                                          input logic sub);
      logic signed [SUM_BITS-1:0] sum;
      speed_type r;
      sum = sub ? (SUM_BITS'(a) - SUM_BITS'(b)) : (SUM_BITS'(a) + SUM_BITS'(b));
      if (sum > SUM_BITS'(DUTY_MAX))
         r = SPEED_BITS'(DUTY_MAX);
      else if (sum < -SUM_BITS'(DUTY_MAX))
         r = -SPEED_BITS'(DUTY_MAX);
      else
         r = sum[SPEED_BITS-1:0];
      return r;
   endfunction

   // Clamp the trim percent and premultiply by the reciprocal of 100
   function automatic logic [COEF_BITS-1:0] trim_coef(input logic [TRIM_BITS-1:0] trim,
                                                      input logic [TRIM_BITS-1:0] lo,
                                                      input logic [TRIM_BITS-1:0] hi);
      logic [TRIM_BITS-1:0] t;
      if (trim < lo)
         t = lo;
      else if (trim > hi)
         t = hi;
      else
         t = trim;
      return COEF_BITS'(t) * COEF_BITS'(RECIP_MUL);
   endfunction

   // Scale a speed by its trim, truncate toward zero, keep nonzero speeds nonzero
   function automatic speed_type trim_speed(input speed_type s,
                                            input logic [COEF_BITS-1:0] coef);
      logic [PROD_BITS-1:0] prod;
      logic [QUOT_BITS-1:0] q;
      duty_type             m;
      speed_type            r;
      prod = PROD_BITS'(speed_mag(s)) * PROD_BITS'(coef);
      q    = prod[PROD_BITS-1:RECIP_SHIFT];
      if (q == '0)
         m = DUTY_BITS'(1);
      else if (q > QUOT_BITS'(DUTY_MAX))
         m = DUTY_BITS'(DUTY_MAX);
      else
         m = q[DUTY_BITS-1:0];
      if (s == '0)
         r = '0;
      else if (s[SPEED_BITS-1])
         r = -SPEED_BITS'(m);
      else
         r = SPEED_BITS'(m);
      return r;
   endfunction

endpackage

// ----- hw/rtl/ddpm_req_if.sv -----
// Command channel of the differential drive PWM mixer.
// Depends on ddpm_pkg for field widths.
`timescale 1ns / 1ps

interface ddpm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [ddpm_pkg::CMD_BITS-1:0]           cmd;
   logic signed [ddpm_pkg::REQ_BITS-1:0]    throttle;
   logic signed [ddpm_pkg::REQ_BITS-1:0]    steering;
   logic [ddpm_pkg::PIN_BITS-1:0]           test_pin;
   logic signed [ddpm_pkg::REQ_BITS-1:0]    test_value;

   modport source (output valid, cmd, throttle, steering, test_pin, test_value,
                   input ready);
   modport sink   (input valid, cmd, throttle, steering, test_pin, test_value,
                   output ready);
endinterface

// ----- hw/rtl/ddpm_rsp_if.sv -----
// Result channel of the differential drive PWM mixer.
// Depends on ddpm_pkg for field widths.
`timescale 1ns / 1ps

interface ddpm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ddpm_pkg::DUTY_BITS-1:0]   left_fwd_duty;
   logic [ddpm_pkg::DUTY_BITS-1:0]   left_rev_duty;
   logic [ddpm_pkg::DUTY_BITS-1:0]   right_fwd_duty;
   logic [ddpm_pkg::DUTY_BITS-1:0]   right_rev_duty;
   logic [ddpm_pkg::DUTY_BITS-1:0]   pin_readback;
   logic                             test_running;

   modport source (output valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                   right_rev_duty, pin_readback, test_running, input ready);
   modport sink   (input valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                   right_rev_duty, pin_readback, test_running, output ready);
endinterface

// ----- hw/rtl/ddpm_csr_if.sv -----
// Register write channel of the differential drive PWM mixer.
// Depends on ddpm_pkg for address and data widths.
`timescale 1ns / 1ps

interface ddpm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ddpm_pkg::CSR_ADDR_BITS-1:0]   addr;
   logic [ddpm_pkg::CSR_DATA_BITS-1:0]   wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ----- hw/rtl/differential_drive_pwm_mixer_unit.sv -----
// Top level of the differential drive PWM mixer with H-bridge duty outputs.
// Depends on ddpm_pkg, ddpm_req_if, ddpm_rsp_if, ddpm_csr_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir   Transaction
// req_ch    in    one command: drive, stop, reapply, pin test or 1 ms tick
// rsp_ch    out   four bridge duties, pin readback, test running flag
// csr_ch    in    one register write, address and data
//
// Each command transaction passes an input register, then the mixer and state
// update logic, and lands in the result register; one transaction per cycle is
// sustained while results are taken. The result register is the only stall point;
// while it is full and not taken, a full input register holds and req_ch.ready drops.
// Synchronous reset returns the registers to their defaults and clears the block state.
// Trim coefficients are registered behind the trim, floor and ceiling registers.

module differential_drive_pwm_mixer_unit (
   input logic        clock,
   input logic        reset,
   ddpm_req_if.sink   req_ch,
   ddpm_rsp_if.source rsp_ch,
   ddpm_csr_if.sink   csr_ch
);

   // Configuration registers
   logic [ddpm_pkg::TRIM_BITS-1:0]  trim_left_ff, trim_right_ff;
   logic [ddpm_pkg::TRIM_BITS-1:0]  trim_floor_ff, trim_ceiling_ff;
   logic                            reverse_left_ff, reverse_right_ff;
   logic [ddpm_pkg::LIMIT_BITS-1:0] watchdog_limit_ff, pin_test_limit_ff;
   logic [ddpm_pkg::COEF_BITS-1:0]  coef_left_ff, coef_left_in;
   logic [ddpm_pkg::COEF_BITS-1:0]  coef_right_ff, coef_right_in;

   // Input register
   logic                            in_valid_ff;
   ddpm_pkg::cmd_type               cmd_ff;
   ddpm_pkg::speed_type             thr_ff, ste_ff;
   logic [ddpm_pkg::PIN_BITS-1:0]   tpin_ff;
   ddpm_pkg::duty_type              tval_ff;

   // Block state
   ddpm_pkg::speed_type             held_thr_ff, held_thr_in;
   ddpm_pkg::speed_type             held_ste_ff, held_ste_in;
   logic [ddpm_pkg::TIMER_BITS-1:0] since_cmd_ff, since_cmd_in;
   logic [ddpm_pkg::TIMER_BITS-1:0] since_test_ff, since_test_in;
   logic                            seen_ff, seen_in;
   logic                            test_ff, test_in;
   ddpm_pkg::duty_type              pin_ff [ddpm_pkg::NUM_PINS];
   ddpm_pkg::duty_type              pin_in [ddpm_pkg::NUM_PINS];
   ddpm_pkg::duty_type              readback_in;

   // Result register
   logic                            rsp_valid_ff;
   ddpm_pkg::duty_type              rsp_duty_ff [ddpm_pkg::NUM_PINS];
   ddpm_pkg::duty_type              rsp_readback_ff;
   logic                            rsp_test_ff;

   // Handshake and datapath
   logic                            out_free;
   logic                            advance;
   logic                            held_nz;
   ddpm_pkg::speed_type             drv_thr, drv_ste;
   ddpm_pkg::speed_type             left_speed, right_speed;
   ddpm_pkg::speed_type             left_neg, right_neg;
   logic [ddpm_pkg::TIMER_BITS-1:0] cmd_inc, test_inc;
   logic                            do_drive, do_stop, test_set;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_left_ff      <= ddpm_pkg::TRIM_RESET;
         trim_right_ff     <= ddpm_pkg::TRIM_RESET;
         reverse_left_ff   <= 1'b0;
         reverse_right_ff  <= 1'b0;
         trim_floor_ff     <= ddpm_pkg::FLOOR_RESET;
         trim_ceiling_ff   <= ddpm_pkg::CEILING_RESET;
         watchdog_limit_ff <= ddpm_pkg::WATCHDOG_RESET;
         pin_test_limit_ff <= ddpm_pkg::PIN_TEST_RESET;
      end else if (csr_ch.valid) begin
         case (ddpm_pkg::csr_addr_type'(csr_ch.addr))
            ddpm_pkg::CSR_TRIM_LEFT:      trim_left_ff      <= csr_ch.wdata[ddpm_pkg::TRIM_BITS-1:0];
            ddpm_pkg::CSR_TRIM_RIGHT:     trim_right_ff     <= csr_ch.wdata[ddpm_pkg::TRIM_BITS-1:0];
            ddpm_pkg::CSR_REVERSE_LEFT:   reverse_left_ff   <= csr_ch.wdata[0];
            ddpm_pkg::CSR_REVERSE_RIGHT:  reverse_right_ff  <= csr_ch.wdata[0];
            ddpm_pkg::CSR_TRIM_FLOOR:     trim_floor_ff     <= csr_ch.wdata[ddpm_pkg::TRIM_BITS-1:0];
            ddpm_pkg::CSR_TRIM_CEILING:   trim_ceiling_ff   <= csr_ch.wdata[ddpm_pkg::TRIM_BITS-1:0];
            ddpm_pkg::CSR_WATCHDOG_LIMIT: watchdog_limit_ff <= csr_ch.wdata[ddpm_pkg::LIMIT_BITS-1:0];
            ddpm_pkg::CSR_PIN_TEST_LIMIT: pin_test_limit_ff <= csr_ch.wdata[ddpm_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the trims and premultiply by the reciprocal of 100
   assign coef_left_in  = ddpm_pkg::trim_coef(trim_left_ff, trim_floor_ff, trim_ceiling_ff);
   assign coef_right_in = ddpm_pkg::trim_coef(trim_right_ff, trim_floor_ff, trim_ceiling_ff);

   always_ff @(posedge clock) begin
      coef_left_ff  <= coef_left_in;
      coef_right_ff <= coef_right_in;
   end

   // Capture a command transaction, clamping its requests
   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_ch.ready)
         in_valid_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff  <= ddpm_pkg::cmd_type'(req_ch.cmd);
         thr_ff  <= ddpm_pkg::clamp_req(req_ch.throttle);
         ste_ff  <= ddpm_pkg::clamp_req(req_ch.steering);
         tpin_ff <= req_ch.test_pin;
         tval_ff <= ddpm_pkg::speed_mag(ddpm_pkg::clamp_req(req_ch.test_value));
      end
   end

   // Mixer: new request for drive, held request for reapply
   assign held_nz  = (held_thr_ff != '0) || (held_ste_ff != '0);
   assign drv_thr  = (cmd_ff == ddpm_pkg::CMD_DRIVE) ? thr_ff : held_thr_ff;
   assign drv_ste  = (cmd_ff == ddpm_pkg::CMD_DRIVE) ? ste_ff : held_ste_ff;
   assign left_speed  = ddpm_pkg::trim_speed(ddpm_pkg::mix_side(drv_thr, drv_ste, 1'b0),
                                             coef_left_ff);
   assign right_speed = ddpm_pkg::trim_speed(ddpm_pkg::mix_side(drv_thr, drv_ste, 1'b1),
                                             coef_right_ff);
   assign left_neg  = -left_speed;
   assign right_neg = -right_speed;

   // Saturating elapsed counters
   assign cmd_inc  = (&since_cmd_ff)  ? since_cmd_ff  : since_cmd_ff + 1'b1;
   assign test_inc = (&since_test_ff) ? since_test_ff : since_test_ff + 1'b1;

   // Next state and result for the transaction in the input register
   always_comb begin
      held_thr_in   = held_thr_ff;
      held_ste_in   = held_ste_ff;
      since_cmd_in  = since_cmd_ff;
      since_test_in = since_test_ff;
      seen_in       = seen_ff;
      test_in       = test_ff;
      pin_in        = pin_ff;
      readback_in   = '0;
      do_drive      = 1'b0;
      do_stop       = 1'b0;
      test_set      = 1'b0;

      if (advance) begin
         case (cmd_ff)
            ddpm_pkg::CMD_DRIVE:   do_drive = 1'b1;
            ddpm_pkg::CMD_STOP:    do_stop  = 1'b1;
            ddpm_pkg::CMD_REAPPLY: do_drive = held_nz;
            ddpm_pkg::CMD_PIN_TEST: begin
               if (!tpin_ff[ddpm_pkg::PIN_BITS-1]) begin
                  do_stop     = 1'b1;
                  test_set    = (tval_ff != '0);
                  readback_in = tval_ff;
               end
            end
            ddpm_pkg::CMD_TICK: begin
               since_cmd_in  = cmd_inc;
               since_test_in = test_inc;
               // coast an expired pin test
               if (test_ff && (ddpm_pkg::CMP_BITS'(test_inc) >
                               ddpm_pkg::CMP_BITS'(pin_test_limit_ff))) begin
                  for (int i = 0; i < ddpm_pkg::NUM_PINS; i++)
                     pin_in[i] = '0;
                  test_in = 1'b0;
               end
               // watchdog: stop on command silence
               if (held_nz && seen_ff && (ddpm_pkg::CMP_BITS'(cmd_inc) >
                                          ddpm_pkg::CMP_BITS'(watchdog_limit_ff)))
                  do_stop = 1'b1;
            end
            default: ;
         endcase
      end

      if (do_stop) begin
         for (int i = 0; i < ddpm_pkg::NUM_PINS; i++)
            pin_in[i] = '0;
         held_thr_in  = '0;
         held_ste_in  = '0;
         since_cmd_in = '0;
         seen_in      = 1'b1;
         test_in      = 1'b0;
      end

      if (test_set) begin
         for (int i = 0; i < ddpm_pkg::NUM_PINS; i++)
            if (tpin_ff[ddpm_pkg::PIN_IDX_BITS-1:0] == ddpm_pkg::PIN_IDX_BITS'(i))
               pin_in[i] = tval_ff;
         test_in       = 1'b1;
         since_test_in = '0;
      end

      if (do_drive) begin
         held_thr_in  = drv_thr;
         held_ste_in  = drv_ste;
         since_cmd_in = '0;
         seen_in      = 1'b1;
         test_in      = 1'b0;
         // split each side into forward and reverse bridge duties
         pin_in[0] = (left_speed > 0)  ? left_speed[ddpm_pkg::DUTY_BITS-1:0]  : '0;
         pin_in[1] = (left_speed < 0)  ? left_neg[ddpm_pkg::DUTY_BITS-1:0]    : '0;
         pin_in[2] = (right_speed > 0) ? right_speed[ddpm_pkg::DUTY_BITS-1:0] : '0;
         pin_in[3] = (right_speed < 0) ? right_neg[ddpm_pkg::DUTY_BITS-1:0]   : '0;
         if (reverse_left_ff) begin
            pin_in[0] = (left_speed < 0) ? left_neg[ddpm_pkg::DUTY_BITS-1:0]   : '0;
            pin_in[1] = (left_speed > 0) ? left_speed[ddpm_pkg::DUTY_BITS-1:0] : '0;
         end
         if (reverse_right_ff) begin
            pin_in[2] = (right_speed < 0) ? right_neg[ddpm_pkg::DUTY_BITS-1:0]   : '0;
            pin_in[3] = (right_speed > 0) ? right_speed[ddpm_pkg::DUTY_BITS-1:0] : '0;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_thr_ff   <= '0;
         held_ste_ff   <= '0;
         since_cmd_ff  <= '0;
         since_test_ff <= '0;
         seen_ff       <= 1'b0;
         test_ff       <= 1'b0;
         for (int i = 0; i < ddpm_pkg::NUM_PINS; i++)
            pin_ff[i] <= '0;
      end else begin
         held_thr_ff   <= held_thr_in;
         held_ste_ff   <= held_ste_in;
         since_cmd_ff  <= since_cmd_in;
         since_test_ff <= since_test_in;
         seen_ff       <= seen_in;
         test_ff       <= test_in;
         pin_ff        <= pin_in;
      end
   end

   // Result register: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_free)
         rsp_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_duty_ff     <= pin_in;
         rsp_readback_ff <= readback_in;
         rsp_test_ff     <= test_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.left_fwd_duty  = rsp_duty_ff[0];
   assign rsp_ch.left_rev_duty  = rsp_duty_ff[1];
   assign rsp_ch.right_fwd_duty = rsp_duty_ff[2];
   assign rsp_ch.right_rev_duty = rsp_duty_ff[3];
   assign rsp_ch.pin_readback   = rsp_readback_ff;
   assign rsp_ch.test_running   = rsp_test_ff;

   // A running pin test drives exactly one pin
   `ASSERT_IMPL(a_test_one_pin, clock, reset, test_ff, $countones({pin_ff[0] != '0, pin_ff[1] != '0, pin_ff[2] != '0, pin_ff[3] != '0}) == 1)

   // A running pin test leaves no held drive request
   `ASSERT_IMPL(a_test_no_held, clock, reset, test_ff, !held_nz)

   // Never drive both inputs of one bridge
   `ASSERT_ALWAYS(a_bridge_safe, clock, reset, !((pin_ff[0] != '0) && (pin_ff[1] != '0)) && !((pin_ff[2] != '0) && (pin_ff[3] != '0)))

   // A stop clears the held request and the silence counter
   `ASSERT_NEXT(a_stop_clears, clock, reset, advance && (cmd_ff == ddpm_pkg::CMD_STOP), !held_nz && (since_cmd_ff == '0) && seen_ff)

endmodule
